/* rtl/core/c_body_stripping_filter_top_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the C body stripping filter
// Shared property forms, clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef C_BODY_STRIPPING_FILTER_TOP_DEFINES_SVH
`define C_BODY_STRIPPING_FILTER_TOP_DEFINES_SVH

// check a condition in the same cycle as its trigger
`define CBSF_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// check a condition in the cycle after its trigger
`define CBSF_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/core/cbsf_pkg.sv */
// ----------------------------------------------------------------------------
// cbsf_pkg
// Types, character codes and the per-byte judge function of the filter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cbsf_pkg;

	localparam int DEPTH_BITS = 16;

	localparam logic [7:0] CH_LBRACE = 8'h7b;
	localparam logic [7:0] CH_RBRACE = 8'h7d;
	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_NL     = 8'h0a;
	localparam logic [7:0] CH_STAR   = 8'h2a;
	localparam logic [7:0] CH_SLASH  = 8'h2f;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_BSLASH = 8'h5c;
	localparam logic [7:0] CH_SEMI   = 8'h3b;

	localparam logic [DEPTH_BITS-1:0] DEPTH_MAX = {1'b0, {(DEPTH_BITS-1){1'b1}}};
	localparam logic [DEPTH_BITS-1:0] DEPTH_MIN = {1'b1, {(DEPTH_BITS-1){1'b0}}};
	localparam logic [DEPTH_BITS-1:0] DEPTH_ZERO = '0;

	typedef struct packed {
		logic [7:0]            held_char;
		logic                  held_present;
		logic [DEPTH_BITS-1:0] depth;
		logic                  in_string;
		logic                  in_char;
		logic                  in_line_cmt;
		logic                  in_block_cmt;
		logic                  in_directive;
		logic                  odd_escapes;
	} scan_state_t;

	typedef struct packed {
		logic [7:0] data;
		logic       keep;
		logic       last;
	} result_t;

	typedef struct packed {
		scan_state_t st;
		result_t     res;
	} judge_t;

	// judge one byte with optional one-byte lookahead
	function automatic judge_t judge(scan_state_t st, logic [7:0] c, logic has_next,
		logic [7:0] nx);
		judge_t o;
		logic   even;
		logic   code;
		o.st = st;
		o.res = '0;
		even = !st.odd_escapes;
		o.st.odd_escapes = (c == CH_BSLASH) ? !st.odd_escapes : 1'b0;
		if (st.in_line_cmt && c == CH_NL) begin
			o.st.in_line_cmt = 1'b0;
		end
		if (st.in_block_cmt && c == CH_STAR && has_next && nx == CH_SLASH) begin
			o.st.in_block_cmt = 1'b0;
		end
		if (st.in_string && c == CH_DQUOTE && even) begin
			o.st.in_string = 1'b0;
			if (st.depth == DEPTH_ZERO) begin
				o.res.data = CH_DQUOTE;
				o.res.keep = 1'b1;
			end
		end else if (st.in_char && c == CH_SQUOTE && even) begin
			o.st.in_char = 1'b0;
			if (st.depth == DEPTH_ZERO) begin
				o.res.data = CH_SQUOTE;
				o.res.keep = 1'b1;
			end
		end else begin
			if (st.in_directive && c == CH_NL) begin
				o.st.in_directive = 1'b0;
			end
			code = !o.st.in_string && !o.st.in_char && !o.st.in_line_cmt &&
				!o.st.in_block_cmt && !o.st.in_directive;
			if (code) begin
				if (c == CH_LBRACE && st.depth != DEPTH_MAX) begin
					o.st.depth = st.depth + 1'b1;
				end
				if (c == CH_RBRACE && st.depth != DEPTH_MIN) begin
					o.st.depth = st.depth - 1'b1;
				end
				if (c == CH_SLASH && has_next && nx == CH_SLASH) begin
					o.st.in_line_cmt = 1'b1;
				end
				if (c == CH_SLASH && has_next && nx == CH_STAR) begin
					o.st.in_block_cmt = 1'b1;
				end
				if (c == CH_DQUOTE) begin
					o.st.in_string = 1'b1;
				end
				if (c == CH_SQUOTE) begin
					o.st.in_char = 1'b1;
				end
				if (c == CH_HASH) begin
					o.st.in_directive = 1'b1;
				end
			end
			if (o.st.depth == DEPTH_ZERO) begin
				o.res.data = (c == CH_RBRACE) ? CH_SEMI : c;
				o.res.keep = 1'b1;
			end
		end
		return o;
	endfunction

endpackage

`default_nettype wire

/* rtl/core/c_body_stripping_filter_top.sv */
// Strips function bodies from C source text streamed one byte per item. Only
// text at brace depth zero is passed on, and every closing brace in it comes
// out as a semicolon. Strings, character literals, comments and preprocessor
// lines are tracked so braces inside them do not count. One byte is held back
// as lookahead, so an item gives the result of the previous byte; an item
// flagged final_byte also gives the result of its own byte with end_of_text
// set and returns the filter to its reset state. Items are taken one per cycle
// unless text_stall is set and pass through the input register and the result
// queue; the output moves one result per cycle unless result_stall is set.
// The input stalls only while the queue has no room because the output is
// stalled; the item after a final item gives at most one result, so a final
// item with two results does not stall a stream whose output never stalls.
// ----------------------------------------------------------------------------
// c_body_stripping_filter_top
// Input register, single-pass judge logic, two-entry result queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "c_body_stripping_filter_top_defines.svh"

module c_body_stripping_filter_top (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       text_valid,
	output logic            text_stall,
	input  wire logic [7:0] text_byte,
	input  wire logic       final_byte,
	output logic            result_valid,
	input  wire logic       result_stall,
	output logic [7:0]      out_byte,
	output logic            byte_valid,
	output logic            end_of_text
);
	import cbsf_pkg::*;

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        fin_s1;
	scan_state_t st_q;
	scan_state_t st_next;
	result_t     queue_q [2];
	result_t     queue_next [2];
	logic [1:0]  cnt_q;
	logic [1:0]  cnt_next;
	logic [1:0]  cnt_after;
	logic [1:0]  room;
	logic [1:0]  nres;
	logic        pop;
	logic        s1_adv;
	logic        accept;
	judge_t      ja;
	judge_t      jb;
	scan_state_t st_mid;
	result_t     p0;
	result_t     p1;

	assign pop        = (cnt_q != 2'd0) && !result_stall;
	assign cnt_after  = cnt_q - {1'b0, pop};
	assign room       = 2'd2 - cnt_after;
	assign nres       = {1'b0, st_q.held_present} + {1'b0, fin_s1};
	assign s1_adv     = valid_s1 && (nres <= room);
	assign text_stall = valid_s1 && !s1_adv;
	assign accept     = text_valid && !text_stall;

	// judge the held byte against the new one, then the new byte on a final item
	always_comb begin
		ja = judge(st_q, st_q.held_char, 1'b1, byte_s1);
		st_mid = st_q.held_present ? ja.st : st_q;
		jb = judge(st_mid, byte_s1, 1'b0, 8'h00);
		if (fin_s1) begin
			st_next = '0;
		end else begin
			st_next = st_mid;
			st_next.held_char = byte_s1;
			st_next.held_present = 1'b1;
		end
		p1 = jb.res;
		p1.last = 1'b1;
		p0 = st_q.held_present ? ja.res : p1;
		p0.last = st_q.held_present ? 1'b0 : 1'b1;
	end

	always_comb begin
		queue_next[0] = pop ? queue_q[1] : queue_q[0];
		queue_next[1] = queue_q[1];
		cnt_next = cnt_after;
		if (s1_adv && nres != 2'd0) begin
			queue_next[cnt_after[0]] = p0;
			cnt_next = cnt_after + nres;
			if (nres == 2'd2) begin
				queue_next[1] = p1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			st_q <= '0;
			cnt_q <= 2'd0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (s1_adv) begin
				valid_s1 <= 1'b0;
			end
			if (s1_adv) begin
				st_q <= st_next;
			end
			cnt_q <= cnt_next;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= text_byte;
			fin_s1 <= final_byte;
		end
		queue_q[0] <= queue_next[0];
		queue_q[1] <= queue_next[1];
	end

	assign result_valid = (cnt_q != 2'd0);
	assign out_byte     = queue_q[0].data;
	assign byte_valid   = queue_q[0].keep;
	assign end_of_text  = queue_q[0].last;

	`CBSF_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_q != 2'd3, "result queue count out of range")
	`CBSF_ASSERT_NOW(a_fits, s1_adv, {1'b0, cnt_after} + {1'b0, nres} <= 3'd2, "queue overrun")
	`CBSF_ASSERT_NEXT(a_fin_clears, s1_adv && fin_s1, st_q == '0, "state kept after final")
	`CBSF_ASSERT_NOW(a_drop_zero, result_valid && !byte_valid, out_byte == 8'h00, "dropped data")

endmodule

`default_nettype wire

/* sim/c_body_stripping_filter_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c_body_stripping_filter_top_tb
// Streams C-like texts through the filter. Every result is checked against an
// in-bench scanner that tracks depth, literals and comments. Both sides idle
// at random. The receiver holds off twice so that the filter backs up.
// ----------------------------------------------------------------------------
module c_body_stripping_filter_top_tb;
	import cbsf_pkg::*;

	typedef struct packed {
		logic [7:0] ch;
		logic       fin;
	} text_item_t;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int HOLD_CYCLES    = 150;
	localparam int IDLE_PCT       = 30;
	localparam int RANDOM_BYTES   = 900;

	logic       clk          = 1'b0;
	logic       arst_n       = 1'b0;
	logic       text_valid   = 1'b0;
	logic [7:0] text_byte    = 8'h00;
	logic       final_byte   = 1'b0;
	logic       result_stall = 1'b0;
	logic       text_stall;
	logic       result_valid;
	logic [7:0] out_byte;
	logic       byte_valid;
	logic       end_of_text;

	c_body_stripping_filter_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.text_valid   (text_valid),
		.text_stall   (text_stall),
		.text_byte    (text_byte),
		.final_byte   (final_byte),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.out_byte     (out_byte),
		.byte_valid   (byte_valid),
		.end_of_text  (end_of_text)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	text_item_t  source_text[$];
	logic [7:0]  txt[$];
	result_t     strip_results[$];

	int unsigned cyc;
	int unsigned items_taken;
	int unsigned total_items;
	int unsigned texts;
	int unsigned results_seen;
	int unsigned errors;
	int unsigned quiet;
	int          depth_hi;
	int          depth_lo;
	logic        took_text = 1'b0;

	// scanner state
	logic [7:0]            held_ch;
	logic                  held_ok;
	logic [DEPTH_BITS-1:0] depth;
	logic                  in_str;
	logic                  in_chr;
	logic                  in_lcmt;
	logic                  in_bcmt;
	logic                  in_dir;
	logic                  odd_bs;

	task automatic clear_scan();
		held_ch = 8'h00;
		held_ok = 1'b0;
		depth   = '0;
		in_str  = 1'b0;
		in_chr  = 1'b0;
		in_lcmt = 1'b0;
		in_bcmt = 1'b0;
		in_dir  = 1'b0;
		odd_bs  = 1'b0;
	endtask

	task automatic strip_byte(input logic [7:0] c, input logic has_next, input logic [7:0] nx,
		input logic last);
		result_t r;
		logic    even;
		logic    code;
		r = '0;
		r.last = last;
		even = !odd_bs;
		odd_bs = (c == CH_BSLASH) ? !odd_bs : 1'b0;
		if (in_lcmt && c == CH_NL)
			in_lcmt = 1'b0;
		if (in_bcmt && c == CH_STAR && has_next && nx == CH_SLASH)
			in_bcmt = 1'b0;
		if (in_str && c == CH_DQUOTE && even) begin
			// closing quote: skip the rest of the scan
			in_str = 1'b0;
			if (depth == '0) begin
				r.data = CH_DQUOTE;
				r.keep = 1'b1;
			end
		end else if (in_chr && c == CH_SQUOTE && even) begin
			in_chr = 1'b0;
			if (depth == '0) begin
				r.data = CH_SQUOTE;
				r.keep = 1'b1;
			end
		end else begin
			if (in_dir && c == CH_NL)
				in_dir = 1'b0;
			code = !in_str && !in_chr && !in_lcmt && !in_bcmt && !in_dir;
			if (code) begin
				if (c == CH_LBRACE && depth != DEPTH_MAX)
					depth = depth + 1'b1;
				if (c == CH_RBRACE && depth != DEPTH_MIN)
					depth = depth - 1'b1;
				if (c == CH_SLASH && has_next && nx == CH_SLASH)
					in_lcmt = 1'b1;
				if (c == CH_SLASH && has_next && nx == CH_STAR)
					in_bcmt = 1'b1;
				if (c == CH_DQUOTE)
					in_str = 1'b1;
				if (c == CH_SQUOTE)
					in_chr = 1'b1;
				if (c == CH_HASH)
					in_dir = 1'b1;
			end
			if (depth == '0) begin
				r.data = (c == CH_RBRACE) ? CH_SEMI : c;
				r.keep = 1'b1;
			end
		end
		if (int'($signed(depth)) > depth_hi)
			depth_hi = int'($signed(depth));
		if (int'($signed(depth)) < depth_lo)
			depth_lo = int'($signed(depth));
		strip_results.push_back(r);
	endtask

	task automatic strip_item(input logic [7:0] c, input logic fin);
		if (held_ok)
			strip_byte(held_ch, 1'b1, c, 1'b0);
		if (fin) begin
			strip_byte(c, 1'b0, 8'h00, 1'b1);
			clear_scan();
		end else begin
			held_ch = c;
			held_ok = 1'b1;
		end
	endtask

	task automatic report_mismatch(input string what, input logic [9:0] want,
		input logic [9:0] got);
		errors++;
		$display("mismatch at result %0d (t=%0t): %s expected %h got %h",
			results_seen, $time, what, want, got);
	endtask

	task automatic check_result();
		result_t r;
		results_seen++;
		if (strip_results.size() == 0) begin
			report_mismatch("unexpected result", 10'h000, {out_byte, byte_valid, end_of_text});
		end else begin
			r = strip_results.pop_front();
			if (out_byte !== r.data)
				report_mismatch("out_byte", {2'b00, r.data}, {2'b00, out_byte});
			if (byte_valid !== r.keep)
				report_mismatch("byte_valid", {9'h000, r.keep}, {9'h000, byte_valid});
			if (end_of_text !== r.last)
				report_mismatch("end_of_text", {9'h000, r.last}, {9'h000, end_of_text});
		end
	endtask

	// ---- text building ----
	task automatic add_str(input string s);
		for (int i = 0; i < s.len(); i++)
			txt.push_back(s.getc(i));
	endtask

	task automatic queue_text();
		text_item_t it;
		for (int i = 0; i < txt.size(); i++) begin
			it.ch  = txt[i];
			it.fin = (i == txt.size() - 1);
			source_text.push_back(it);
		end
		txt.delete();
		texts++;
	endtask

	task automatic pick_from(input string pool, input int n);
		repeat (n)
			txt.push_back(pool.getc($urandom_range(pool.len() - 1)));
	endtask

	task automatic add_fragment();
		case ($urandom_range(15))
		0, 1, 2: begin
			repeat ($urandom_range(1, 5))
				txt.push_back(8'(8'h61 + $urandom_range(25)));
		end
		3: txt.push_back(CH_LBRACE);
		4: txt.push_back(CH_RBRACE);
		5: begin
			txt.push_back(CH_DQUOTE);
			pick_from("ab{}\\\"'/*", $urandom_range(0, 6));
			txt.push_back(CH_DQUOTE);
		end
		6: begin
			txt.push_back(CH_SQUOTE);
			if ($urandom_range(1))
				txt.push_back(CH_BSLASH);
			pick_from("a\\{}'", 1);
			txt.push_back(CH_SQUOTE);
		end
		7: begin
			add_str("//");
			pick_from("a{}*/'\"\\", $urandom_range(0, 6));
			txt.push_back(CH_NL);
		end
		8: begin
			add_str("/*");
			pick_from("a{}*/\n", $urandom_range(0, 6));
			add_str("*/");
		end
		9: begin
			add_str("#define M {");
			if ($urandom_range(1))
				add_str("\\\n}");
			txt.push_back(CH_NL);
		end
		10: txt.push_back($urandom_range(1) ? CH_NL : 8'h20);
		11: begin
			if ($urandom_range(1))
				add_str("/*/");
			else
				add_str("*//*");
		end
		12: txt.push_back(8'($urandom_range(255)));
		13: begin
			repeat ($urandom_range(1, 4))
				txt.push_back(CH_BSLASH);
		end
		14: begin
			if ($urandom_range(1))
				txt.push_back(CH_SEMI);
			else
				add_str("()");
		end
		default: txt.push_back(CH_SLASH);
		endcase
	endtask

	// ---- driver: offer pending items at the falling edge ----
	always @(negedge clk) begin
		if (!arst_n) begin
			text_valid <= 1'b0;
		end else if (!text_valid || took_text) begin
			if (source_text.size() != 0 &&
				((cyc >= 400 && cyc < 700) || $urandom_range(99) >= IDLE_PCT)) begin
				text_valid <= 1'b1;
				text_byte  <= source_text[0].ch;
				final_byte <= source_text[0].fin;
				source_text.pop_front();
			end else begin
				text_valid <= 1'b0;
			end
		end
	end

	// ---- receiver: random stalls plus two long hold-offs ----
	int unsigned recv_cyc;
	int unsigned hold_left;

	always @(negedge clk) begin
		if (!arst_n) begin
			result_stall <= 1'b0;
		end else if (hold_left != 0) begin
			result_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (recv_cyc == 150 || recv_cyc == 900) begin
			result_stall <= 1'b1;
			hold_left <= HOLD_CYCLES;
		end else begin
			result_stall <= !(cyc >= 400 && cyc < 700) && ($urandom_range(99) < IDLE_PCT);
		end
		recv_cyc <= recv_cyc + 1;
	end

	// ---- monitor: predict on accepted items, check accepted results ----
	always @(posedge clk) begin
		if (arst_n) begin
			if (text_valid && !text_stall) begin
				strip_item(text_byte, final_byte);
				items_taken++;
			end
			if (result_valid && !result_stall)
				check_result();
		end
		took_text <= arst_n && text_valid && !text_stall;
		cyc <= cyc + 1;
	end

	// ---- watchdog ----
	always @(posedge clk) begin
		if (arst_n) begin
			if ((text_valid && !text_stall) || (result_valid && !result_stall))
				quiet <= 0;
			else
				quiet <= quiet + 1;
			if (quiet >= WATCHDOG_LIMIT) begin
				$display("watchdog: nothing moved for %0d cycles, %0d results outstanding",
					quiet, strip_results.size());
				$display("c_body_stripping_filter_top_tb: FAIL");
				$finish;
			end
		end
	end

	initial begin
		int unsigned rand_bytes;
		clear_scan();
		depth_hi = 0;
		depth_lo = 0;

		// directed texts
		add_str("a");
		queue_text();
		txt.push_back(8'h00);
		txt.push_back(8'hff);
		queue_text();
		add_str("x{y}z");
		queue_text();
		// unbalanced closing brace
		add_str("}q{");
		queue_text();
		// closing brace inside a literal at depth zero
		add_str("\"}\"");
		queue_text();
		// escaped backslash before the closing quote
		add_str("'\\\\'");
		queue_text();
		// adjacent comment markers
		add_str("/**//*");
		queue_text();

		// random texts, mostly well formed
		rand_bytes = 0;
		while (rand_bytes < RANDOM_BYTES) begin
			if ($urandom_range(9) == 0) begin
				repeat ($urandom_range(1, 20))
					txt.push_back(8'($urandom_range(255)));
			end else begin
				repeat ($urandom_range(1, 12))
					add_fragment();
			end
			rand_bytes += txt.size();
			queue_text();
		end

		total_items = source_text.size();

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		wait (items_taken == total_items);
		wait (strip_results.size() == 0);
		repeat (16) @(posedge clk);

		$display("ran %0d texts, %0d bytes, %0d results checked", texts, total_items,
			results_seen);
		$display("depth swept from %0d to %0d, %0d mismatches", depth_lo, depth_hi, errors);
		if (errors == 0) begin
			$display("c_body_stripping_filter_top_tb: PASS");
		end else begin
			$display("c_body_stripping_filter_top_tb: FAIL");
		end
		$finish;
	end

endmodule
